@@ src/lbs_pkg.sv @@
`timescale 1ns / 1ps

package lbs_pkg;

  // Coordinate width, signed with ten fraction bits at the default width.
  localparam int COORD_WIDTH = 20;

  // Bone matrices: two bones with three packed rows each.
  localparam int NUM_ROWS   = 6;
  localparam int ROWS_PER_BONE = 3;
  localparam int ROW_BITS   = 64;
  localparam int COEF_BITS  = 16;
  localparam int COEF_FRAC  = 10;
  localparam int NUM_AXES   = 3;
  localparam int TRANS_SLOT = 3;
  localparam int WEIGHT_BITS = 9;

  // Configuration address map: one 64-bit register every eight bytes.
  localparam int REG_IDX_W = $clog2(NUM_ROWS);
  localparam int ADDR_W    = REG_IDX_W + 3;

  // Datapath widths through the pipeline.
  localparam int PROD_W = COORD_WIDTH + COEF_BITS;
  localparam int ROW_W  = COORD_WIDTH + COEF_BITS + 2;
  localparam int WROW_W = ROW_W + WEIGHT_BITS + 1;
  localparam int ACC_W  = WROW_W + 1;

  // Final rounding: 28 fraction bits down to 10, round half up.
  localparam int ROUND_SHIFT = 18;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BONE0_ROW_X,
    REG_BONE0_ROW_Y,
    REG_BONE0_ROW_Z,
    REG_BONE1_ROW_X,
    REG_BONE1_ROW_Y,
    REG_BONE1_ROW_Z
  } lbs_reg_e;

  typedef logic [NUM_ROWS-1:0][ROW_BITS-1:0] row_arr_t;

  // Identity rows with no translation.
  localparam logic [ROW_BITS-1:0] ROW_X_RESET = ROW_BITS'(1024);
  localparam logic [ROW_BITS-1:0] ROW_Y_RESET = ROW_BITS'(1024) << 16;
  localparam logic [ROW_BITS-1:0] ROW_Z_RESET = ROW_BITS'(1024) << 32;
  localparam row_arr_t ROW_RESET = {ROW_Z_RESET, ROW_Y_RESET, ROW_X_RESET,
                                    ROW_Z_RESET, ROW_Y_RESET, ROW_X_RESET};

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic [WEIGHT_BITS-1:0]        weight_a;
    logic [WEIGHT_BITS-1:0]        weight_b;
    logic                          last_in;
  } lbs_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] skinned_x;
    logic signed [COORD_WIDTH-1:0] skinned_y;
    logic signed [COORD_WIDTH-1:0] skinned_z;
    logic                          last_out;
  } lbs_out_t;

  // Side data that travels with each vertex alongside the row sums.
  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight_a;
    logic [WEIGHT_BITS-1:0] weight_b;
    logic                   last;
  } lbs_side_t;

  // Handshake between two pipeline sections.
  typedef struct packed {
    logic valid;
  } lbs_hs_t;

endpackage

@@ src/lbs_cfg_regs.sv @@
`timescale 1ns / 1ps

module lbs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbs_pkg::ADDR_W-1:0]    paddr,
  input  logic [lbs_pkg::ROW_BITS-1:0]  pwdata,
  output logic [lbs_pkg::ROW_BITS-1:0]  prdata,
  output logic                          pready,
  output lbs_pkg::row_arr_t             rows_o
);

  lbs_pkg::row_arr_t                  rows_q;
  logic [lbs_pkg::REG_IDX_W-1:0]      reg_idx;
  logic                               wr_en;

  assign reg_idx = paddr[lbs_pkg::ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign rows_o  = rows_q;

  // Register file; writes to addresses beyond the last row are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= lbs_pkg::ROW_RESET;
    end else if (wr_en) begin
      case (lbs_pkg::lbs_reg_e'(reg_idx))
        lbs_pkg::REG_BONE0_ROW_X: rows_q[lbs_pkg::REG_BONE0_ROW_X] <= pwdata;
        lbs_pkg::REG_BONE0_ROW_Y: rows_q[lbs_pkg::REG_BONE0_ROW_Y] <= pwdata;
        lbs_pkg::REG_BONE0_ROW_Z: rows_q[lbs_pkg::REG_BONE0_ROW_Z] <= pwdata;
        lbs_pkg::REG_BONE1_ROW_X: rows_q[lbs_pkg::REG_BONE1_ROW_X] <= pwdata;
        lbs_pkg::REG_BONE1_ROW_Y: rows_q[lbs_pkg::REG_BONE1_ROW_Y] <= pwdata;
        lbs_pkg::REG_BONE1_ROW_Z: rows_q[lbs_pkg::REG_BONE1_ROW_Z] <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back; unmapped addresses read as zero.
  always_comb begin
    case (lbs_pkg::lbs_reg_e'(reg_idx))
      lbs_pkg::REG_BONE0_ROW_X: prdata = rows_q[lbs_pkg::REG_BONE0_ROW_X];
      lbs_pkg::REG_BONE0_ROW_Y: prdata = rows_q[lbs_pkg::REG_BONE0_ROW_Y];
      lbs_pkg::REG_BONE0_ROW_Z: prdata = rows_q[lbs_pkg::REG_BONE0_ROW_Z];
      lbs_pkg::REG_BONE1_ROW_X: prdata = rows_q[lbs_pkg::REG_BONE1_ROW_X];
      lbs_pkg::REG_BONE1_ROW_Y: prdata = rows_q[lbs_pkg::REG_BONE1_ROW_Y];
      lbs_pkg::REG_BONE1_ROW_Z: prdata = rows_q[lbs_pkg::REG_BONE1_ROW_Z];
      default:                  prdata = '0;
    endcase
  end

  // A write to a mapped row lands in that row.
  a_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (reg_idx < lbs_pkg::REG_IDX_W'(lbs_pkg::NUM_ROWS)))
      |=> (rows_q[$past(reg_idx)] == $past(pwdata)))
    else $error("configuration write did not reach its row");

  // A write beyond the last row changes nothing.
  a_unmapped_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (reg_idx >= lbs_pkg::REG_IDX_W'(lbs_pkg::NUM_ROWS))) |=> $stable(rows_q))
    else $error("unmapped write altered the bone rows");

endmodule

@@ src/lbs_xform.sv @@
`timescale 1ns / 1ps

module lbs_xform (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  lbs_pkg::lbs_in_t                   in_data_i,
  output logic                               in_ready_o,
  input  lbs_pkg::row_arr_t                  rows_i,
  output lbs_pkg::lbs_hs_t                   sum_hs_o,
  input  logic                               sum_ready_i,
  output logic signed [lbs_pkg::ROW_W-1:0]   row_sum_o [lbs_pkg::NUM_ROWS],
  output lbs_pkg::lbs_side_t                 side_o
);

  logic signed [lbs_pkg::COORD_WIDTH-1:0] pos [lbs_pkg::NUM_AXES];
  logic signed [lbs_pkg::PROD_W-1:0] prod_d [lbs_pkg::NUM_ROWS][lbs_pkg::NUM_AXES];
  logic signed [lbs_pkg::PROD_W-1:0] prod_q [lbs_pkg::NUM_ROWS][lbs_pkg::NUM_AXES];
  logic signed [lbs_pkg::ROW_W-1:0]  sum_d  [lbs_pkg::NUM_ROWS];
  logic signed [lbs_pkg::ROW_W-1:0]  sum_q  [lbs_pkg::NUM_ROWS];
  lbs_pkg::lbs_side_t                side1_q, side2_q;
  logic                              v1_q, v2_q;
  logic                              ready1, ready2;

  assign pos[0] = in_data_i.pos_x;
  assign pos[1] = in_data_i.pos_y;
  assign pos[2] = in_data_i.pos_z;

  // A stage takes a new request when it is empty or its content moves on.
  assign ready2     = !v2_q || sum_ready_i;
  assign ready1     = !v1_q || ready2;
  assign in_ready_o = ready1;

  // Stage one: all eighteen coefficient products at once.
  // Stage two: the three products of a row plus its translation.
  for (genvar r = 0; r < lbs_pkg::NUM_ROWS; r++) begin : g_row
    logic signed [lbs_pkg::COEF_BITS-1:0] trans;
    for (genvar c = 0; c < lbs_pkg::NUM_AXES; c++) begin : g_col
      logic signed [lbs_pkg::COEF_BITS-1:0] coef;
      assign coef        = rows_i[r][lbs_pkg::COEF_BITS*c +: lbs_pkg::COEF_BITS];
      assign prod_d[r][c] = coef * pos[c];
    end
    assign trans    = rows_i[r][lbs_pkg::COEF_BITS*lbs_pkg::TRANS_SLOT +: lbs_pkg::COEF_BITS];
    assign sum_d[r] = lbs_pkg::ROW_W'(prod_q[r][0]) + lbs_pkg::ROW_W'(prod_q[r][1])
                    + lbs_pkg::ROW_W'(prod_q[r][2])
                    + (lbs_pkg::ROW_W'(trans) <<< lbs_pkg::COEF_FRAC);
  end

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= in_valid_i;
      if (ready2) v2_q <= v1_q;
    end
  end

  // Payload registers load only with a valid request.
  always_ff @(posedge clk_i) begin
    if (ready1 && in_valid_i) begin
      prod_q  <= prod_d;
      side1_q <= '{weight_a: in_data_i.weight_a,
                   weight_b: in_data_i.weight_b,
                   last:     in_data_i.last_in};
    end
    if (ready2 && v1_q) begin
      sum_q   <= sum_d;
      side2_q <= side1_q;
    end
  end

  assign sum_hs_o.valid = v2_q;
  assign row_sum_o      = sum_q;
  assign side_o         = side2_q;

  // The input is held off only when both stages are occupied.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q))
    else $error("input held off with a free stage");

  // A request in stage one that may advance shows up in stage two.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && ready2) |=> v2_q)
    else $error("request lost between product and sum stages");

endmodule

@@ src/lbs_blend.sv @@
`timescale 1ns / 1ps

module lbs_blend (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lbs_pkg::lbs_hs_t                   sum_hs_i,
  output logic                               sum_ready_o,
  input  logic signed [lbs_pkg::ROW_W-1:0]   row_sum_i [lbs_pkg::NUM_ROWS],
  input  lbs_pkg::lbs_side_t                 side_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output lbs_pkg::lbs_out_t                  out_data_o
);

  localparam logic signed [lbs_pkg::ACC_W-1:0] ROUND_BIAS =
    lbs_pkg::ACC_W'(1) <<< (lbs_pkg::ROUND_SHIFT - 1);
  localparam logic signed [lbs_pkg::ACC_W-1:0] SAT_HI =
    lbs_pkg::ACC_W'((64'd1 << (lbs_pkg::COORD_WIDTH - 1)) - 64'd1);
  localparam logic signed [lbs_pkg::ACC_W-1:0] SAT_LO = -SAT_HI - lbs_pkg::ACC_W'(1);

  logic signed [lbs_pkg::WEIGHT_BITS:0]     wa_s, wb_s;
  logic signed [lbs_pkg::WROW_W-1:0]        wsum_d [lbs_pkg::NUM_ROWS];
  logic signed [lbs_pkg::WROW_W-1:0]        wsum_q [lbs_pkg::NUM_ROWS];
  logic signed [lbs_pkg::COORD_WIDTH-1:0]   coord_d [lbs_pkg::NUM_AXES];
  logic                                     last3_q;
  logic                                     v3_q, out_v_q;
  logic                                     ready3, ready4;
  lbs_pkg::lbs_out_t                        out_q;

  assign ready4      = !out_v_q || !out_stall_i;
  assign ready3      = !v3_q || ready4;
  assign sum_ready_o = ready3;

  // Weights are unsigned; a zero on top lets them enter a signed product.
  assign wa_s = {1'b0, side_i.weight_a};
  assign wb_s = {1'b0, side_i.weight_b};

  // Stage three: each row sum scaled by the weight of its bone.
  for (genvar r = 0; r < lbs_pkg::NUM_ROWS; r++) begin : g_weight
    if (r < lbs_pkg::ROWS_PER_BONE) begin : g_bone0
      assign wsum_d[r] = row_sum_i[r] * wa_s;
    end else begin : g_bone1
      assign wsum_d[r] = row_sum_i[r] * wb_s;
    end
  end

  // Stage four: blend both bones, round half up and saturate.
  for (genvar k = 0; k < lbs_pkg::NUM_AXES; k++) begin : g_axis
    logic signed [lbs_pkg::ACC_W-1:0] acc;
    logic signed [lbs_pkg::ACC_W-1:0] rnd;
    assign acc = lbs_pkg::ACC_W'(wsum_q[k])
               + lbs_pkg::ACC_W'(wsum_q[k + lbs_pkg::ROWS_PER_BONE]) + ROUND_BIAS;
    assign rnd = acc >>> lbs_pkg::ROUND_SHIFT;
    always_comb begin
      if (rnd > SAT_HI) begin
        coord_d[k] = SAT_HI[lbs_pkg::COORD_WIDTH-1:0];
      end else if (rnd < SAT_LO) begin
        coord_d[k] = SAT_LO[lbs_pkg::COORD_WIDTH-1:0];
      end else begin
        coord_d[k] = rnd[lbs_pkg::COORD_WIDTH-1:0];
      end
    end
  end

  // Valid bits of the weighting stage and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (ready3) v3_q    <= sum_hs_i.valid;
      if (ready4) out_v_q <= v3_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ready3 && sum_hs_i.valid) begin
      wsum_q  <= wsum_d;
      last3_q <= side_i.last;
    end
    if (ready4 && v3_q) begin
      out_q <= '{skinned_x: coord_d[0],
                 skinned_y: coord_d[1],
                 skinned_z: coord_d[2],
                 last_out:  last3_q};
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // A weighted request that may advance reaches the output register.
  a_reach_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && ready4) |=> out_v_q)
    else $error("request lost before the output register");

  // A result taken with nothing behind it is not shown again.
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_stall_i && !v3_q) |=> !out_v_q)
    else $error("result repeated after it was taken");

endmodule

@@ src/two_bone_linear_blend_skinning.sv @@
`timescale 1ns / 1ps

// Two-bone linear blend skinning: each vertex request is transformed by two
// affine bone matrices, weighted and blended into one skinned position per
// request. One vertex is accepted every clock cycle unless the input is held
// off, and each result passes through four register stages: coefficient
// products, row sums, weight products, and the blend with round-half-up and
// saturation. A stall at the output backs the pipeline up stage by stage, and
// empty stages still fill, so the input is held off only when every stage is
// occupied. The six bone rows sit at byte addresses 0 to 40 in steps of eight
// on a 64-bit register port and are to be written while no vertex is in flight.

module two_bone_linear_blend_skinning (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lbs_pkg::lbs_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lbs_pkg::lbs_out_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbs_pkg::ADDR_W-1:0]    paddr,
  input  logic [lbs_pkg::ROW_BITS-1:0]  pwdata,
  output logic [lbs_pkg::ROW_BITS-1:0]  prdata,
  output logic                          pready
);

  lbs_pkg::row_arr_t                   rows;
  lbs_pkg::lbs_hs_t                    sum_hs;
  lbs_pkg::lbs_side_t                  side;
  logic                                in_ready;
  logic                                sum_ready;
  logic signed [lbs_pkg::ROW_W-1:0]    row_sum [lbs_pkg::NUM_ROWS];

  assign in_stall_o = !in_ready;

  // Bone matrix registers.
  lbs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rows_o  (rows)
  );

  // Matrix-vector products for both bones.
  lbs_xform u_xform (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready),
    .rows_i      (rows),
    .sum_hs_o    (sum_hs),
    .sum_ready_i (sum_ready),
    .row_sum_o   (row_sum),
    .side_o      (side)
  );

  // Weighting, blend, rounding and saturation.
  lbs_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_hs_i    (sum_hs),
    .sum_ready_o (sum_ready),
    .row_sum_i   (row_sum),
    .side_i      (side),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
